@@ design/tlge_pkg.sv @@
`timescale 1ns / 1ps

package tlge_pkg;

    // Field and bus widths
    localparam int DIM_W      = 7;
    localparam int COORD_W    = 6;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_ADDR_W = 1;

    // Largest grid dimension a 7-bit register can express
    localparam int MAX_DIM = (1 << DIM_W) - 1;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_USE,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Three vertically stacked bits of one column: {upper, middle, lower}
    typedef logic [2:0] col_win_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic in_use;
    } cell_ctrl_t;

endpackage

@@ design/tlge_ram.sv @@
`timescale 1ns / 1ps

module tlge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tlge_cell.sv @@
`timescale 1ns / 1ps

module tlge_cell (
    input  logic                  aclk,
    input  tlge_pkg::cell_ctrl_t  ctrl,
    input  logic                  row_bit,
    input  tlge_pkg::col_win_t    left_win,
    input  tlge_pkg::col_win_t    right_win,
    output tlge_pkg::col_win_t    own_win,
    output logic                  next_bit
);

    import tlge_pkg::*;

    logic       upper_reg;
    logic       middle_reg;
    logic       lower_reg;
    logic [3:0] live;

    // Slide the three-row window down by one row
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            upper_reg  <= middle_reg;
            middle_reg <= lower_reg;
            lower_reg  <= row_bit;
        end
    end

    assign own_win = {upper_reg, middle_reg, lower_reg};

    // Count the eight neighbors and apply birth on 3, survival on 2 or 3
    always_comb begin
        live = 4'(left_win[2]) + 4'(left_win[1]) + 4'(left_win[0])
             + 4'(right_win[2]) + 4'(right_win[1]) + 4'(right_win[0])
             + 4'(upper_reg) + 4'(lower_reg);
        next_bit = ctrl.in_use && ((live == 4'd3) || (middle_reg && (live == 4'd2)));
    end

endmodule

@@ design/toroidal_life_generation_engine.sv @@
`timescale 1ns / 1ps

// Game of Life engine (birth on 3, survival on 2 or 3) on a wrapping grid.
// Input words on s_*: write one cell, advance one generation, or read one cell.
// Every input word yields exactly one result word on m_*.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata set grid width (index 0) and
// grid height (index 1); write only while the engine is idle.
// A write or a read passes through ST_LOOK, ST_USE and ST_EMIT before m_tvalid
// rises; a cell outside the grid or an unused command goes straight to ST_EMIT;
// an advance passes through ST_STEP, where the source buffer is streamed one row per
// cycle through the row RAM read port into a chain of column cells holding a
// three-row window, and each cell emits its next-generation bit while the
// following row arrives.
// One word is in progress at a time, so a new word is taken only once the
// result of the last one is loaded. s_tready rises at the edge that loads the
// result into the output register, so a new word can be taken while that
// result waits on m_tready.
// When the receiver stalls, the result is held in the output register and a
// following result waits in the engine until it is taken.
// Reset clears both grid buffers through per-row valid bits, selects buffer 0
// and sets both dimensions to their maximum; no clearing pass is needed.
module toroidal_life_generation_engine #(
    parameter int MAX_WIDTH  = tlge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tlge_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tlge_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tlge_pkg::DIM_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cmd[1:0], row_index[7:2], column_index[13:8], cell_in[14], zero[15]
    input  logic [tlge_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_out[0], step_done[1], zero[7:2]
    output logic [tlge_pkg::M_TDATA_W-1:0]     m_tdata
);

    import tlge_pkg::*;

    localparam int USED_ROWS = (MAX_HEIGHT < MAX_DIM) ? MAX_HEIGHT : MAX_DIM;
    localparam int ROW_W     = $clog2(USED_ROWS);
    localparam int ROWS      = 2 ** ROW_W;
    localparam int ADDR_W    = ROW_W + 1;
    localparam int CNT_W     = ROW_W + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Configuration
    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;

    // Input word fields
    logic [CMD_W-1:0]   in_cmd;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic               in_cell;
    logic               in_inside;
    logic               s_accept;

    // Sequencer state
    state_t             state_reg, state_next;
    logic               active_reg, active_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic               cell_reg, cell_next;
    logic               is_write_reg, is_write_next;
    logic               pend_cell_reg, pend_cell_next;
    logic               pend_done_reg, pend_done_next;
    logic [ROW_W-1:0]   rd_row_reg, rd_row_next;
    logic [CNT_W-1:0]   rd_left_reg, rd_left_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [1:0]         fill_reg, fill_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [ROW_W-1:0]   wr_row_reg, wr_row_next;
    logic               step_shift;
    logic               out_load;

    // Row storage and per-row valid bits
    logic [ROWS-1:0]      vld_reg [2];
    logic [ROWS-1:0]      vld_next [2];
    logic                 rd_vld_reg;
    logic [ROW_W-1:0]     row_a;
    logic [COL_W-1:0]     col_idx;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [MAX_WIDTH-1:0] ram_rdata;
    logic                 ram_we;
    logic [MAX_WIDTH-1:0] row_word;
    logic [MAX_WIDTH-1:0] bit_mask;
    logic [MAX_WIDTH-1:0] next_row;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Column chain
    col_win_t win [MAX_WIDTH];
    col_win_t last_win;

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= DIM_W'(MAX_WIDTH);
            grid_height_reg <= DIM_W'(USED_ROWS);
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_GRID_WIDTH) begin
                grid_width_reg <= cfg_wdata;
            end else begin
                grid_height_reg <= cfg_wdata;
            end
        end
    end

    // Clamp dimensions to the supported range
    always_comb begin
        if (grid_width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (grid_width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = grid_width_reg;
        end
        if (grid_height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (grid_height_reg > DIM_W'(USED_ROWS)) begin
            h_eff = DIM_W'(USED_ROWS);
        end else begin
            h_eff = grid_height_reg;
        end
    end

    assign w_m1 = COL_W'(w_eff - DIM_W'(1));
    assign h_m1 = ROW_W'(h_eff - DIM_W'(1));

    // Unpack the input word
    assign in_cmd    = s_tdata[1:0];
    assign in_row    = s_tdata[7:2];
    assign in_col    = s_tdata[13:8];
    assign in_cell   = s_tdata[14];
    assign in_inside = (DIM_W'(in_row) < h_eff) && (DIM_W'(in_col) < w_eff);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cell_next      = cell_reg;
        is_write_next  = is_write_reg;
        pend_cell_next = pend_cell_reg;
        pend_done_next = pend_done_reg;
        rd_row_next    = rd_row_reg;
        rd_left_next   = rd_left_reg;
        rd_pend_next   = 1'b0;
        fill_next      = fill_reg;
        wr_pend_next   = 1'b0;
        wr_row_next    = wr_row_reg;
        step_shift     = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    row_next       = in_row;
                    col_next       = in_col;
                    cell_next      = in_cell;
                    is_write_next  = (in_cmd == CMD_WRITE);
                    pend_cell_next = 1'b0;
                    pend_done_next = 1'b0;
                    if (in_cmd == CMD_STEP) begin
                        rd_row_next  = h_m1;
                        rd_left_next = CNT_W'(h_eff) + CNT_W'(2);
                        fill_next    = 2'd0;
                        wr_row_next  = '0;
                        state_next   = ST_STEP;
                    end else if (in_inside && (in_cmd inside {CMD_WRITE, CMD_READ})) begin
                        state_next = ST_LOOK;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOOK: begin
                state_next = ST_USE;
            end
            ST_USE: begin
                if (!is_write_reg) begin
                    pend_cell_next = row_word[col_idx];
                end
                state_next = ST_EMIT;
            end
            ST_STEP: begin
                // issue source rows: last, 0, 1, ..., last, 0
                if (rd_left_reg != '0) begin
                    rd_pend_next = 1'b1;
                    rd_left_next = rd_left_reg - CNT_W'(1);
                    rd_row_next  = (rd_row_reg == h_m1) ? '0 : rd_row_reg + ROW_W'(1);
                end
                // shift arriving rows into the window; write once it is full
                if (rd_pend_reg) begin
                    step_shift = 1'b1;
                    if (fill_reg != 2'd2) begin
                        fill_next = fill_reg + 2'd1;
                    end
                    wr_pend_next = (fill_reg == 2'd2);
                end
                if (wr_pend_reg) begin
                    wr_row_next = wr_row_reg + ROW_W'(1);
                    if (wr_row_reg == h_m1) begin
                        active_next    = ~active_reg;
                        pend_done_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            rd_left_reg <= '0;
            fill_reg    <= 2'd0;
            wr_row_reg  <= '0;
            rd_row_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            rd_pend_reg <= rd_pend_next;
            wr_pend_reg <= wr_pend_next;
            rd_left_reg <= rd_left_next;
            fill_reg    <= fill_next;
            wr_row_reg  <= wr_row_next;
            rd_row_reg  <= rd_row_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        cell_reg      <= cell_next;
        is_write_reg  <= is_write_next;
        pend_cell_reg <= pend_cell_next;
        pend_done_reg <= pend_done_next;
    end

    // Row storage addressing
    assign row_a     = ROW_W'(row_reg);
    assign col_idx   = COL_W'(col_reg);
    assign ram_raddr = {active_reg, (state_reg == ST_STEP) ? rd_row_reg : row_a};
    assign row_word  = rd_vld_reg ? ram_rdata : '0;
    assign bit_mask  = MAX_WIDTH'(1) << col_idx;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {active_reg, row_a};
        ram_wdata = (row_word & ~bit_mask) | (cell_reg ? bit_mask : '0);
        if (state_reg == ST_USE && is_write_reg) begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_STEP && wr_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = {~active_reg, wr_row_reg};
            ram_wdata = next_row;
        end
    end

    tlge_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (2 * ROWS)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Drop the target buffer at step start, mark rows as they are written
    always_comb begin
        vld_next[0] = vld_reg[0];
        vld_next[1] = vld_reg[1];
        if (s_accept && in_cmd == CMD_STEP) begin
            vld_next[~active_reg] = '0;
        end
        if (ram_we) begin
            vld_next[ram_waddr[ADDR_W-1]][ram_waddr[ROW_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= '0;
            vld_reg[1] <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            vld_reg[0] <= vld_next[0];
            vld_reg[1] <= vld_next[1];
            rd_vld_reg <= vld_reg[ram_raddr[ADDR_W-1]][ram_raddr[ROW_W-1:0]];
        end
    end

    // Chain of column cells with wrap at the grid width
    assign last_win = win[w_m1];

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
        col_win_t   left_w;
        col_win_t   right_w;
        cell_ctrl_t ctrl;

        if (c == 0) begin : g_left_wrap
            assign left_w = last_win;
        end else begin : g_left
            assign left_w = win[c-1];
        end

        if (c == MAX_WIDTH - 1) begin : g_right_wrap
            assign right_w = win[0];
        end else begin : g_right
            assign right_w = (w_m1 == COL_W'(c)) ? win[0] : win[c+1];
        end

        assign ctrl = '{shift: step_shift, in_use: (DIM_W'(c) < w_eff)};

        tlge_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .row_bit   (row_word[c]),
            .left_win  (left_w),
            .right_win (right_w),
            .own_win   (win[c]),
            .next_bit  (next_row[c])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - 2){1'b0}}, pend_done_reg, pend_cell_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Step writes land only in the inactive buffer
    a_step_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_STEP) |-> (ram_waddr[ADDR_W-1] != active_reg))
        else $error("step write hit the active buffer");

    // New rows stay inside the configured height
    a_wr_row: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> (wr_row_reg <= h_m1))
        else $error("step wrote past the grid height");

    // Finishing a step flips the active buffer
    a_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && state_next == ST_EMIT) |=> (active_reg != $past(active_reg)))
        else $error("active buffer did not flip after a step");

    // A result never reports both a read value and a completed step
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(pend_cell_reg && pend_done_reg))
        else $error("result mixes read and step completion");

endmodule
